@@ rtl/bec_pkg.sv @@
// Shared types, constants and helpers for the Bezier envelope curve point block.
// Used by bec_blend and the top level; no dependencies.
package bec_pkg;

  localparam int TABLE_POINTS = 1024;
  localparam int SPAN_W       = $clog2(TABLE_POINTS);
  localparam int IDX_W        = 10;
  localparam int T_W          = 24;
  localparam int HALVINGS     = 17;
  localparam int DIV_W        = 35;
  localparam int CRD_W        = 24;
  localparam int CO_W         = 29;

  localparam logic [T_W:0]   T_ONE  = {1'b1, {T_W{1'b0}}};
  localparam logic [T_W-1:0] T_HALF = {1'b1, {(T_W-1){1'b0}}};

  localparam logic REG_PEAK   = 1'b0;
  localparam logic REG_POINTS = 1'b1;

  typedef logic [11:0] auth_t;

  localparam auth_t CTL1_X [8] = '{12'd250, 12'd840, 12'd400, 12'd2170,
                                   12'd400, 12'd1140, 12'd200, 12'd0};
  localparam auth_t CTL1_Y [8] = '{12'd1500, 12'd1780, 12'd430, 12'd3610,
                                   12'd1380, 12'd3750, 12'd2700, 12'd4095};
  localparam auth_t CTL2_X [8] = '{12'd1500, 12'd1160, 12'd920, 12'd3730,
                                   12'd3830, 12'd1850, 12'd720, 12'd4095};
  localparam auth_t CTL2_Y [8] = '{12'd250, 12'd210, 12'd420, 12'd2610,
                                   12'd2890, 12'd1080, 12'd3050, 12'd0};

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [CRD_W-1:0]  p1x;
    logic [CRD_W-1:0]  p1y;
    logic [CRD_W-1:0]  p2x;
    logic [CRD_W-1:0]  p2y;
    logic [SPAN_W-1:0] rem;
    logic [DIV_W-1:0]  nq;
  } div_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CRD_W-1:0] p1x;
    logic [CRD_W-1:0] p1y;
    logic [CRD_W-1:0] p2x;
    logic [CRD_W-1:0] p2y;
    logic [DIV_W-1:0] target;
    logic [T_W:0]     lo;
    logic [T_W:0]     hi;
    logic [T_W-1:0]   mid;
    logic [T_W-1:0]   tlast;
  } item_t;

  function automatic logic [CRD_W-1:0] scale_ctl(auth_t a, logic [15:0] pk);
    logic [27:0] p;
    p = 28'(a) * 28'(pk) + 28'd8;
    return p[27:4];
  endfunction

  // one restoring quotient bit
  function automatic div_t div_step(div_t d, logic [SPAN_W-1:0] sp);
    logic [SPAN_W:0] tr;
    logic [SPAN_W:0] df;
    logic            ge;
    div_t            r;
    tr = {d.rem, d.nq[DIV_W-1]};
    df = tr - {1'b0, sp};
    ge = (tr >= {1'b0, sp});
    r = d;
    r.rem = ge ? df[SPAN_W-1:0] : tr[SPAN_W-1:0];
    r.nq  = {d.nq[DIV_W-2:0], ge};
    return r;
  endfunction

endpackage

@@ rtl/bec_blend.sv @@
// Four-stage cubic Bezier coordinate evaluator: weights from t, then blend.
// Depends on bec_pkg.
module bec_blend (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  bec_pkg::item_t             in_item,
  input  logic [bec_pkg::T_W-1:0]    t,
  input  logic [bec_pkg::CRD_W-1:0]  p0,
  input  logic [bec_pkg::CRD_W-1:0]  p1,
  input  logic [bec_pkg::CRD_W-1:0]  p2,
  input  logic [bec_pkg::CRD_W-1:0]  p3,
  output logic                       out_valid,
  output bec_pkg::item_t             out_item,
  output logic [bec_pkg::CO_W-1:0]   coord
);
  import bec_pkg::*;

  logic             v1, v2, v3;
  item_t            it1, it2, it3;
  logic [T_W:0]     u1;
  logic [T_W-1:0]   t1;
  logic [49:0]      uu1;
  logic [47:0]      tt1;
  logic [CRD_W-1:0] a1 [4];
  logic [CRD_W-1:0] a2 [4];
  logic [49:0]      m0;
  logic [48:0]      m1, m2;
  logic [47:0]      m3;
  logic [48:0]      q0;
  logic [50:0]      q1, q2;
  logic [47:0]      q3;

  logic [T_W:0]   u_c;
  logic [T_W:0]   u2_c;
  logic [T_W-1:0] t2_c;
  logic [50:0]    tm1_c, tm2_c;
  logic [T_W:0]   w0_c;
  logic [26:0]    w1_c, w2_c;
  logic [T_W-1:0] w3_c;
  logic [52:0]    sum_c;

  always_comb begin
    u_c   = T_ONE - {1'b0, t};
    u2_c  = uu1[48:24];
    t2_c  = tt1[47:24];
    tm1_c = {2'b00, m1} + {1'b0, m1, 1'b0};
    tm2_c = {2'b00, m2} + {1'b0, m2, 1'b0};
    w0_c  = m0[48:24];
    w1_c  = tm1_c[50:24];
    w2_c  = tm2_c[50:24];
    w3_c  = m3[47:24];
    sum_c = 53'(q0) + 53'(q1) + 53'(q2) + 53'(q3) + 53'(T_HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1   <= in_item;
      u1    <= u_c;
      t1    <= t;
      uu1   <= 50'(u_c) * 50'(u_c);
      tt1   <= 48'(t) * 48'(t);
      a1[0] <= p0;
      a1[1] <= p1;
      a1[2] <= p2;
      a1[3] <= p3;

      it2 <= it1;
      a2  <= a1;
      m0  <= 50'(u2_c) * 50'(u1);
      m1  <= 49'(u2_c) * 49'(t1);
      m2  <= 49'(u1) * 49'(t2_c);
      m3  <= 48'(t2_c) * 48'(t1);

      it3 <= it2;
      q0  <= 49'(w0_c) * 49'(a2[0]);
      q1  <= 51'(w1_c) * 51'(a2[1]);
      q2  <= 51'(w2_c) * 51'(a2[2]);
      q3  <= 48'(w3_c) * 48'(a2[3]);

      out_item <= it3;
      coord    <= sum_c[52:24];
    end
  end

endmodule

@@ rtl/bezier_envelope_curve_point.sv @@
// Top level of the Bezier envelope curve point evaluator.
// Depends on bec_pkg and bec_blend.
//
// Requests enter on in_valid/in_ready with curve_select, point_index and
// attack_order; each gives one result on out_valid/out_ready carrying
// curve_level and echoed_index, in request order.
// peak_value (address 0) and point_count (address 4) sit on the APB port;
// write them only while no request is in flight.
// Stages from an input transfer to out_valid, in order:
//   1 stage for index select and control point scaling,
//   35 stages of restoring division for the target x (one quotient bit each),
//   17 bisection steps of 5 stages (4-stage Bezier evaluator plus update),
//   4 stages for the final y evaluation, 1 output register.
// Throughput: one transfer per cycle on each side while out_ready is high.
// Output: a two-entry buffer; the pipeline keeps accepting while one result
//   waits and halts as a whole only when both entries are full, out_ready
//   is low and a finished result waits to enter. Nothing is lost or repeated.
// Reset (rst, synchronous): clears all valid bits and the output buffer,
//   sets peak_value to 4095 and point_count to 1024.
module bezier_envelope_curve_point (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  curve_select,
  input  logic [9:0]  point_index,
  input  logic        attack_order,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] curve_level,
  output logic [9:0]  echoed_index
);
  import bec_pkg::*;

  logic [15:0] peak_value;
  logic [10:0] point_count;

  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_value  <= 16'd4095;
      point_count <= 11'd1024;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_PEAK:   peak_value  <= pwdata[15:0];
        REG_POINTS: point_count <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_PEAK:   prdata = {16'd0, peak_value};
      REG_POINTS: prdata = {21'd0, point_count};
      default:    prdata = 32'd0;
    endcase
  end

  // front stage
  logic [10:0]       pts;
  logic [10:0]       spw;
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] isel;
  logic [16:0]       pk1;
  logic [26:0]       pi;
  div_t              f_c;
  logic [CRD_W-1:0]  bpk;

  always_comb begin
    if (point_count < 11'd2) begin
      pts = 11'd2;
    end else if (point_count > 11'(TABLE_POINTS)) begin
      pts = 11'(TABLE_POINTS);
    end else begin
      pts = point_count;
    end
    spw  = pts - 11'd1;
    span = spw[SPAN_W-1:0];
    if (attack_order) begin
      isel = (point_index >= span) ? '0 : span - point_index;
    end else begin
      isel = point_index;
    end
    pk1 = 17'(peak_value) + 17'd1;
    pi  = 27'(pk1) * 27'(isel);
    f_c.idx = point_index;
    f_c.p1x = scale_ctl(CTL1_X[curve_select], peak_value);
    f_c.p1y = scale_ctl(CTL1_Y[curve_select], peak_value);
    f_c.p2x = scale_ctl(CTL2_X[curve_select], peak_value);
    f_c.p2y = scale_ctl(CTL2_Y[curve_select], peak_value);
    f_c.rem = '0;
    f_c.nq  = 35'({pi, 8'd0}) + 35'(span >> 1);
    bpk     = {peak_value, 8'd0};
  end

  // division pipeline
  div_t dq [DIV_W+1];
  logic dv [DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq[0] <= f_c;
    end
  end

  for (genvar k = 1; k <= DIV_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= dv[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dq[k] <= div_step(dq[k-1], span);
      end
    end
  end

  item_t s0;
  always_comb begin
    s0.idx    = dq[DIV_W].idx;
    s0.p1x    = dq[DIV_W].p1x;
    s0.p1y    = dq[DIV_W].p1y;
    s0.p2x    = dq[DIV_W].p2x;
    s0.p2y    = dq[DIV_W].p2y;
    s0.target = dq[DIV_W].nq;
    s0.lo     = '0;
    s0.hi     = T_ONE;
    s0.mid    = T_HALF;
    s0.tlast  = '0;
  end

  // bisection steps
  item_t            ps  [HALVINGS];
  logic             psv [HALVINGS];
  item_t            bi  [HALVINGS];
  logic             bv  [HALVINGS];
  logic [CO_W-1:0]  bc  [HALVINGS];

  for (genvar j = 0; j < HALVINGS; j++) begin : g_step
    item_t        si;
    logic         sv;
    item_t        nx;
    logic [T_W+1:0] ms;

    if (j == 0) begin : g_first
      assign si = s0;
      assign sv = dv[DIV_W];
    end else begin : g_next
      assign si = ps[j-1];
      assign sv = psv[j-1];
    end

    bec_blend u_x (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (sv),
      .in_item  (si),
      .t        (si.mid),
      .p0       ('0),
      .p1       (si.p1x),
      .p2       (si.p2x),
      .p3       (bpk),
      .out_valid(bv[j]),
      .out_item (bi[j]),
      .coord    (bc[j])
    );

    always_comb begin
      nx = bi[j];
      if (35'(bc[j]) < bi[j].target) begin
        nx.lo = {1'b0, bi[j].mid};
      end else begin
        nx.hi = {1'b0, bi[j].mid};
      end
      ms       = 26'(nx.lo) + 26'(nx.hi);
      nx.mid   = ms[T_W:1];
      nx.tlast = bi[j].mid;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        psv[j] <= 1'b0;
      end else if (en) begin
        psv[j] <= bv[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ps[j] <= nx;
      end
    end
  end

  // y at the last midpoint
  logic            yv;
  item_t           yi;
  logic [CO_W-1:0] yc;

  bec_blend u_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (psv[HALVINGS-1]),
    .in_item  (ps[HALVINGS-1]),
    .t        (ps[HALVINGS-1].tlast),
    .p0       (bpk),
    .p1       (ps[HALVINGS-1].p1y),
    .p2       (ps[HALVINGS-1].p2y),
    .p3       ('0),
    .out_valid(yv),
    .out_item (yi),
    .coord    (yc)
  );

  logic [29:0] ysum;
  logic [21:0] lraw;
  logic [15:0] lvl;

  always_comb begin
    ysum = 30'(yc) + 30'd128;
    lraw = ysum[29:8];
    lvl  = (lraw > 22'(peak_value)) ? peak_value : lraw[15:0];
  end

  // output buffer
  logic [1:0]  cnt;
  logic [15:0] q_lvl [2];
  logic [9:0]  q_idx [2];
  logic        push, pop;

  assign en        = ~yv | (cnt != 2'd2) | out_ready;
  assign in_ready  = en;
  assign push      = en & yv;
  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q_lvl[0] <= q_lvl[1];
      q_idx[0] <= q_idx[1];
    end
    if (push) begin
      if ((cnt == 2'd0) || ((cnt == 2'd1) && pop)) begin
        q_lvl[0] <= lvl;
        q_idx[0] <= yi.idx;
      end else begin
        q_lvl[1] <= lvl;
        q_idx[1] <= yi.idx;
      end
    end
  end

  assign curve_level  = q_lvl[0];
  assign echoed_index = q_idx[0];

endmodule

@@ rtl/bec_checker.sv @@
// Port-level assertions for the Bezier envelope curve point block, and the
// bind that attaches them to the top level.
module bec_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output buffer");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind bezier_envelope_curve_point bec_checker u_bec_checker (.*);
